FILE: sv/bud_pkg.sv
`default_nettype none
package bud_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int ENVELOPE_BITS_DEF = 24;

    localparam int COEF_W  = 16;
    localparam int THR_W   = 15;
    localparam int DEPTH_W = 16;
    localparam int FRAC_W  = 16;   // internal gain is Q.16
    localparam int GAIN_W  = 20;   // holds up to 10.0 in Q.16
    localparam int GOUT_W  = 16;   // gain_applied, Q4.12
    localparam int EXC_W   = 36;   // clamped boost excess
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [COEF_W-1:0]  ATTACK_RST  = 16'd4;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 16'd0;
    localparam logic [THR_W-1:0]   UP_RST      = 15'd8192;
    localparam logic [THR_W-1:0]   DOWN_RST    = 15'd13107;
    localparam logic [DEPTH_W-1:0] DEPTH_RST   = 16'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE   = 16'd32768;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 20'd65536;
    localparam logic [GAIN_W-1:0] GAIN_CAP   = 20'd655360;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR = 20'd6553;
    localparam logic [GOUT_W-1:0] GOUT_MIN   = 16'd409;
    localparam logic [GOUT_W-1:0] GOUT_MAX   = 16'd40960;

    // any excess at or above this saturates the gain whenever depth is nonzero
    localparam logic [EXC_W-1:0] EXC_CLAMP = 36'h8_0000_0000;

    localparam longint unsigned FLOOR_DIV = 100000;

    typedef enum logic [2:0] {
        REG_ATTACK,
        REG_RELEASE,
        REG_UP,
        REG_DOWN,
        REG_DEPTH
    } bud_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0]  attack_coefficient;
        logic [COEF_W-1:0]  release_coefficient;
        logic [THR_W-1:0]   up_threshold;
        logic [THR_W-1:0]   down_threshold;
        logic [DEPTH_W-1:0] depth_amount;
    } bud_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bud_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV,
        ST_ENV_UPD,
        ST_UP_CHK,
        ST_UP_DIV,
        ST_UP_GAIN,
        ST_DN_CHK,
        ST_DN_DIV,
        ST_DN_CUT,
        ST_DN_GAIN,
        ST_OUT_MUL,
        ST_OUT
    } bud_state_t;

    function automatic int mul_a_w(int sb, int eb);
        int w;
        w = EXC_W;
        if (eb > w) w = eb;
        if (sb > w) w = sb;
        return w;
    endfunction

    // threshold in envelope format, shifted up by the Q.16 fraction
    function automatic int div_n_w(int eb);
        return eb + FRAC_W - 1;
    endfunction

endpackage
`default_nettype wire

FILE: sv/bud_regs.sv
`default_nettype none
module bud_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bud_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bud_pkg::DATA_W-1:0]  pwdata,
    output logic      [bud_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output bud_pkg::bud_cfg_t                cfg
);

    bud_pkg::bud_cfg_t cfg_reg, cfg_next;
    bud_pkg::bud_reg_t sel;
    logic              wr_en;

    assign sel    = bud_pkg::bud_reg_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                bud_pkg::REG_ATTACK:  cfg_next.attack_coefficient  = pwdata[15:0];
                bud_pkg::REG_RELEASE: cfg_next.release_coefficient = pwdata[15:0];
                bud_pkg::REG_UP:      cfg_next.up_threshold        = pwdata[14:0];
                bud_pkg::REG_DOWN:    cfg_next.down_threshold      = pwdata[14:0];
                bud_pkg::REG_DEPTH:   cfg_next.depth_amount        = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            bud_pkg::REG_ATTACK:  prdata = 32'(cfg_reg.attack_coefficient);
            bud_pkg::REG_RELEASE: prdata = 32'(cfg_reg.release_coefficient);
            bud_pkg::REG_UP:      prdata = 32'(cfg_reg.up_threshold);
            bud_pkg::REG_DOWN:    prdata = 32'(cfg_reg.down_threshold);
            bud_pkg::REG_DEPTH:   prdata = 32'(cfg_reg.depth_amount);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_coefficient  <= bud_pkg::ATTACK_RST;
            cfg_reg.release_coefficient <= bud_pkg::RELEASE_RST;
            cfg_reg.up_threshold        <= bud_pkg::UP_RST;
            cfg_reg.down_threshold      <= bud_pkg::DOWN_RST;
            cfg_reg.depth_amount        <= bud_pkg::DEPTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/bud_mul.sv
`default_nettype none
module bud_mul #(
    parameter int A_W = 36,
    parameter int B_W = 20
) (
    input  wire logic                 aclk,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic      [A_W+B_W-1:0]   prod
);

    logic [A_W+B_W-1:0] prod_reg, prod_next;

    assign prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

FILE: sv/bud_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module bud_div #(
    parameter int N_W = 39,
    parameter int D_W = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [N_W-1:0]        dividend,
    input  wire logic [D_W-1:0]        divisor,
    output logic      [N_W-1:0]        quotient,
    output bud_pkg::bud_div_stat_t     stat
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[N_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

FILE: sv/bud_core.sv
`default_nettype none
module bud_core #(
    parameter int SAMPLE_BITS   = bud_pkg::SAMPLE_BITS_DEF,
    parameter int ENVELOPE_BITS = bud_pkg::ENVELOPE_BITS_DEF,
    parameter int MUL_A_W       = bud_pkg::mul_a_w(SAMPLE_BITS, ENVELOPE_BITS),
    parameter int DIV_N_W       = bud_pkg::div_n_w(ENVELOPE_BITS)
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  bud_pkg::bud_cfg_t                         cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [SAMPLE_BITS-1:0]               in_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [SAMPLE_BITS-1:0]               out_sample,
    output logic      [bud_pkg::GOUT_W-1:0]           out_gain,
    output logic      [MUL_A_W-1:0]                   mul_a,
    output logic      [bud_pkg::GAIN_W-1:0]           mul_b,
    input  wire logic [MUL_A_W+bud_pkg::GAIN_W-1:0]   mul_p,
    output logic                                      div_start,
    output logic      [DIV_N_W-1:0]                   div_dividend,
    output logic      [ENVELOPE_BITS-1:0]             div_divisor,
    input  wire logic [DIV_N_W-1:0]                   div_quotient,
    input  bud_pkg::bud_div_stat_t                    div_stat
);

    localparam int SB    = SAMPLE_BITS;
    localparam int EB    = ENVELOPE_BITS;
    localparam int GW    = bud_pkg::GAIN_W;
    localparam int P_W   = MUL_A_W + GW;
    localparam int AB_W  = SB + EB;
    localparam int SH_L  = (EB >= SB) ? EB - SB : 0;
    localparam int SH_R  = (EB >= SB) ? 0 : SB - EB;
    localparam int QX_W  = (DIV_N_W > bud_pkg::EXC_W) ? DIV_N_W : bud_pkg::EXC_W;
    localparam int R_W   = bud_pkg::FRAC_W + 1;
    localparam logic [EB-1:0] FLOOR_ENV =
        EB'((64'd1 << (EB - 1)) / bud_pkg::FLOOR_DIV);
    localparam logic [R_W-1:0] ONE_R = R_W'(bud_pkg::GAIN_ONE);

    bud_pkg::bud_state_t state_reg, state_next;

    logic [SB-1:0]     sample_reg, sample_next;
    logic [EB-1:0]     env_reg, env_next;
    logic              rise_reg, rise_next;
    logic [GW-1:0]     gain_reg, gain_next;
    logic              oval_reg, oval_next;
    logic [SB-1:0]     osmp_reg, osmp_next;
    logic [bud_pkg::GOUT_W-1:0] ogain_reg, ogain_next;

    logic                    neg;
    logic [SB-1:0]           mag;
    logic [AB_W-1:0]         mag_ext;
    logic [EB-1:0]           absq;
    logic [EB-1:0]           diff;
    logic [EB-1:0]           step;
    logic [bud_pkg::DEPTH_W-1:0] depth;
    logic [EB-1:0]           up_env;
    logic [EB-1:0]           dn_env;
    logic [QX_W-1:0]         excess;
    logic [QX_W-1:0]         excess_c;
    logic [P_W-1:0]          boost;
    logic [R_W-1:0]          span;
    logic [R_W-1:0]          cut;
    logic [R_W-1:0]          factor;
    logic [P_W-1:0]          scaled;
    logic [P_W-1:0]          rnd;
    logic [P_W-1:0]          lim;
    logic [P_W-1:0]          sat;
    logic [SB-1:0]           sat_sb;
    logic [SB-1:0]           res;

    assign neg     = sample_reg[SB-1];
    assign mag     = neg ? (~sample_reg + 1'b1) : sample_reg;
    assign mag_ext = (AB_W'(mag) << SH_L) >> SH_R;
    assign absq    = mag_ext[EB-1:0];
    assign diff    = (absq > env_reg) ? (absq - env_reg) : (env_reg - absq);
    assign step    = EB'(mul_p >> bud_pkg::FRAC_W);
    assign depth   = (cfg.depth_amount > bud_pkg::DEPTH_ONE) ? bud_pkg::DEPTH_ONE
                                                             : cfg.depth_amount;
    assign up_env  = EB'(cfg.up_threshold) << (EB - bud_pkg::FRAC_W);
    assign dn_env  = EB'(cfg.down_threshold) << (EB - bud_pkg::FRAC_W);

    assign excess   = QX_W'(div_quotient) - QX_W'(bud_pkg::GAIN_ONE);
    assign excess_c = (excess > QX_W'(bud_pkg::EXC_CLAMP)) ? QX_W'(bud_pkg::EXC_CLAMP)
                                                           : excess;
    assign boost    = mul_p >> (bud_pkg::FRAC_W - 1);
    // down ratio stays below one, so the low bits of the quotient hold it whole
    assign span     = ONE_R - div_quotient[R_W-1:0];
    assign cut      = R_W'(mul_p >> (bud_pkg::FRAC_W - 1));
    assign factor   = ONE_R - cut;
    assign scaled   = mul_p >> bud_pkg::FRAC_W;

    assign rnd    = (mul_p + P_W'(32768)) >> bud_pkg::FRAC_W;
    assign lim    = neg ? (P_W'(1) << (SB - 1)) : ((P_W'(1) << (SB - 1)) - 1'b1);
    assign sat    = (rnd > lim) ? lim : rnd;
    assign sat_sb = sat[SB-1:0];
    assign res    = neg ? (~sat_sb + 1'b1) : sat_sb;

    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        env_next     = env_reg;
        rise_next    = rise_reg;
        gain_next    = gain_reg;
        oval_next    = oval_reg && !out_ready;
        osmp_next    = osmp_reg;
        ogain_next   = ogain_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = env_reg;
        in_ready     = (state_reg == bud_pkg::ST_IDLE);

        case (state_reg)
            bud_pkg::ST_IDLE: begin
                if (in_valid) begin
                    sample_next = in_sample;
                    state_next  = bud_pkg::ST_ENV;
                end
            end
            bud_pkg::ST_ENV: begin
                mul_a      = MUL_A_W'(diff);
                mul_b      = (absq > env_reg) ? GW'(cfg.attack_coefficient)
                                              : GW'(cfg.release_coefficient);
                rise_next  = absq > env_reg;
                state_next = bud_pkg::ST_ENV_UPD;
            end
            bud_pkg::ST_ENV_UPD: begin
                env_next   = rise_reg ? (env_reg + step) : (env_reg - step);
                state_next = bud_pkg::ST_UP_CHK;
            end
            bud_pkg::ST_UP_CHK: begin
                gain_next = bud_pkg::GAIN_ONE;
                if (env_reg < up_env && env_reg > FLOOR_ENV) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_N_W'(up_env) << bud_pkg::FRAC_W;
                    state_next   = bud_pkg::ST_UP_DIV;
                end else begin
                    state_next = bud_pkg::ST_DN_CHK;
                end
            end
            bud_pkg::ST_UP_DIV: begin
                if (div_stat.done) begin
                    mul_a      = MUL_A_W'(excess_c);
                    mul_b      = GW'(depth);
                    state_next = bud_pkg::ST_UP_GAIN;
                end
            end
            bud_pkg::ST_UP_GAIN: begin
                if (boost > P_W'(bud_pkg::GAIN_CAP - bud_pkg::GAIN_ONE))
                    gain_next = bud_pkg::GAIN_CAP;
                else
                    gain_next = bud_pkg::GAIN_ONE + GW'(boost);
                state_next = bud_pkg::ST_DN_CHK;
            end
            bud_pkg::ST_DN_CHK: begin
                if (env_reg > dn_env) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_N_W'(dn_env) << bud_pkg::FRAC_W;
                    state_next   = bud_pkg::ST_DN_DIV;
                end else begin
                    state_next = bud_pkg::ST_OUT_MUL;
                end
            end
            bud_pkg::ST_DN_DIV: begin
                if (div_stat.done) begin
                    mul_a      = MUL_A_W'(span);
                    mul_b      = GW'(depth);
                    state_next = bud_pkg::ST_DN_CUT;
                end
            end
            bud_pkg::ST_DN_CUT: begin
                mul_a      = MUL_A_W'(gain_reg);
                mul_b      = GW'(factor);
                state_next = bud_pkg::ST_DN_GAIN;
            end
            bud_pkg::ST_DN_GAIN: begin
                if (scaled < P_W'(bud_pkg::GAIN_FLOOR))
                    gain_next = bud_pkg::GAIN_FLOOR;
                else
                    gain_next = GW'(scaled);
                state_next = bud_pkg::ST_OUT_MUL;
            end
            bud_pkg::ST_OUT_MUL: begin
                mul_a      = MUL_A_W'(mag);
                mul_b      = gain_reg;
                state_next = bud_pkg::ST_OUT;
            end
            bud_pkg::ST_OUT: begin
                // keep the product in place while waiting
                mul_a = MUL_A_W'(mag);
                mul_b = gain_reg;
                // hold here while the previous result is still pending
                if (!oval_reg || out_ready) begin
                    oval_next  = 1'b1;
                    osmp_next  = res;
                    ogain_next = bud_pkg::GOUT_W'(gain_reg >> 4);
                    state_next = bud_pkg::ST_IDLE;
                end
            end
            default: state_next = bud_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bud_pkg::ST_IDLE;
            env_reg   <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            env_reg   <= env_next;
            oval_reg  <= oval_next;
        end
        sample_reg <= sample_next;
        rise_reg   <= rise_next;
        gain_reg   <= gain_next;
        osmp_reg   <= osmp_next;
        ogain_reg  <= ogain_next;
    end

    assign out_valid  = oval_reg;
    assign out_sample = osmp_reg;
    assign out_gain   = ogain_reg;

endmodule
`default_nettype wire

FILE: sv/band_up_down_compressor.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_axis    in         s_tvalid / s_tready  s_tdata: sample_in
// m_axis    out        m_tvalid / m_tready  m_tdata: sample_out, gain_applied
// apb       in         psel/penable/pready  five config registers at 4*i
//
// A new sample is taken only in the idle state, after the previous one has
// been processed; samples in the boost or cut range also wait on the divider,
// which gives one quotient bit per cycle and is shared by both gain paths.
// Reset (aresetn low, synchronous) loads register defaults and clears the envelope.
// A pending result that is not taken holds the last step until m_tready.
module band_up_down_compressor #(
    parameter int SAMPLE_BITS   = bud_pkg::SAMPLE_BITS_DEF,
    parameter int ENVELOPE_BITS = bud_pkg::ENVELOPE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [SAMPLE_BITS-1:0] sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [SAMPLE_BITS-1:0] sample_out, [SAMPLE_BITS+15:SAMPLE_BITS] gain_applied
    output logic      [((SAMPLE_BITS+23)/8)*8-1:0]     m_tdata,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [bud_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [bud_pkg::DATA_W-1:0]            pwdata,
    output logic      [bud_pkg::DATA_W-1:0]            prdata,
    output logic                                       pready
);

    localparam int MUL_A_W = bud_pkg::mul_a_w(SAMPLE_BITS, ENVELOPE_BITS);
    localparam int DIV_N_W = bud_pkg::div_n_w(ENVELOPE_BITS);
    localparam int GW      = bud_pkg::GAIN_W;
    localparam int OUT_TW  = ((SAMPLE_BITS + 23) / 8) * 8;

    bud_pkg::bud_cfg_t      cfg;
    bud_pkg::bud_div_stat_t div_stat;

    logic [MUL_A_W-1:0]       mul_a;
    logic [GW-1:0]            mul_b;
    logic [MUL_A_W+GW-1:0]    mul_p;
    logic                     div_start;
    logic [DIV_N_W-1:0]       div_dividend;
    logic [ENVELOPE_BITS-1:0] div_divisor;
    logic [DIV_N_W-1:0]       div_quotient;
    logic [SAMPLE_BITS-1:0]   out_sample;
    logic [bud_pkg::GOUT_W-1:0] out_gain;

    bud_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bud_mul #(
        .A_W (MUL_A_W),
        .B_W (GW)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    bud_div #(
        .N_W (DIV_N_W),
        .D_W (ENVELOPE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    bud_core #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .ENVELOPE_BITS (ENVELOPE_BITS),
        .MUL_A_W       (MUL_A_W),
        .DIV_N_W       (DIV_N_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_sample    (s_tdata[SAMPLE_BITS-1:0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sample   (out_sample),
        .out_gain     (out_gain),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .div_stat     (div_stat)
    );

    assign m_tdata = OUT_TW'({out_gain, out_sample});

    // gain leaving the block stays between the cut floor and the boost cap
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SAMPLE_BITS+15:SAMPLE_BITS] >= bud_pkg::GOUT_MIN) &&
                     (m_tdata[SAMPLE_BITS+15:SAMPLE_BITS] <= bud_pkg::GOUT_MAX))
        else $error("gain_applied out of range");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_div_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (div_stat.busy && !div_stat.done))
        else $error("divider did not start");

endmodule
`default_nettype wire

FILE: dv/band_compressor_checker.sv
`timescale 1ns / 1ps
module band_compressor_checker
    import bud_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // [15:0] sample_in
    input  logic [15:0]         s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] sample_out, [31:16] gain_applied
    input  logic [31:0]         m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output int                  mismatch_count,
    output int                  results_pending
);

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int EB = ENVELOPE_BITS_DEF;
    localparam bit [63:0] ENV_FLOOR  = (64'd1 << (EB - 1)) / FLOOR_DIV;
    localparam bit [63:0] EXCESS_MAX = 64'd1 << 40;
    localparam bit [63:0] ENV_MASK   = (64'd1 << EB) - 1;

    // field order matches m_tdata, lowest bits last in the struct
    typedef struct packed {
        logic [15:0]   gain_applied;
        logic [SB-1:0] sample_out;
    } comp_out_t;

    typedef struct {
        comp_out_t     res;
        logic [EB-1:0] env;
    } comp_step_t;

    bud_cfg_t      cfg;
    logic [EB-1:0] envelope;
    comp_out_t     awaited_outputs[$];
    int            mismatches;

    function automatic comp_step_t compress_sample(input logic [SB-1:0] raw,
                                                   input logic [EB-1:0] env_in,
                                                   input bud_cfg_t c);
        bit [63:0]  mag, absq, env, depth, up, down, gain, ratio, excess, cut, factor, prod;
        bit         neg;
        comp_step_t r;
        neg  = raw[SB-1];
        mag  = 64'(raw);
        if (neg) mag = (64'd1 << SB) - mag;
        absq = mag << (EB - SB);
        env  = 64'(env_in);
        if (absq > env) begin
            env = env + ((64'(c.attack_coefficient) * (absq - env)) >> 16);
        end else begin
            env = env - ((64'(c.release_coefficient) * (env - absq)) >> 16);
        end
        env &= ENV_MASK;

        depth = (c.depth_amount > DEPTH_ONE) ? 64'(DEPTH_ONE) : 64'(c.depth_amount);
        up    = 64'(c.up_threshold) << (EB - 16);
        down  = 64'(c.down_threshold) << (EB - 16);
        gain  = 64'(GAIN_ONE);

        // boost only above the noise floor
        if (env < up && env > ENV_FLOOR) begin
            ratio  = (up << FRAC_W) / env;
            excess = ratio - 64'(GAIN_ONE);
            if (excess > EXCESS_MAX) excess = EXCESS_MAX;
            gain = 64'(GAIN_ONE) + ((excess * depth) >> 15);
            if (gain > 64'(GAIN_CAP)) gain = 64'(GAIN_CAP);
        end
        if (env > down) begin
            ratio  = (down << FRAC_W) / env;
            cut    = ((64'(GAIN_ONE) - ratio) * depth) >> 15;
            factor = 64'(GAIN_ONE) - cut;
            gain   = (gain * factor) >> FRAC_W;
            if (gain < 64'(GAIN_FLOOR)) gain = 64'(GAIN_FLOOR);
        end

        prod = (mag * gain + 64'd32768) >> FRAC_W;
        if (neg) begin
            if (prod > (64'd1 << (SB - 1))) prod = 64'd1 << (SB - 1);
            r.res.sample_out = SB'(64'd0 - prod);
        end else begin
            if (prod > (64'd1 << (SB - 1)) - 1) prod = (64'd1 << (SB - 1)) - 1;
            r.res.sample_out = SB'(prod);
        end
        r.res.gain_applied = 16'(gain >> 4);
        r.env = EB'(env);
        return r;
    endfunction

    always @(posedge aclk) begin
        comp_step_t nxt;
        comp_out_t  got;
        comp_out_t  want;
        if (!aresetn) begin
            cfg = '{ATTACK_RST, RELEASE_RST, UP_RST, DOWN_RST, DEPTH_RST};
            envelope = '0;
            awaited_outputs.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (bud_reg_t'(paddr[ADDR_W-1:2]))
                    REG_ATTACK:  cfg.attack_coefficient  = pwdata[COEF_W-1:0];
                    REG_RELEASE: cfg.release_coefficient = pwdata[COEF_W-1:0];
                    REG_UP:      cfg.up_threshold        = pwdata[THR_W-1:0];
                    REG_DOWN:    cfg.down_threshold      = pwdata[THR_W-1:0];
                    REG_DEPTH:   cfg.depth_amount        = pwdata[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            // pop before push so a same-edge input can never match an early result
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (awaited_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result sample_out=%h gain_applied=%h",
                                 $realtime, got.sample_out, got.gain_applied);
                end else begin
                    want = awaited_outputs.pop_front();
                    if (got.sample_out !== want.sample_out ||
                        got.gain_applied !== want.gain_applied) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch sample_out exp=%h got=%h, ",
                                      "gain_applied exp=%h got=%h"}, $realtime,
                                     want.sample_out, got.sample_out,
                                     want.gain_applied, got.gain_applied);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                nxt = compress_sample(s_tdata[SB-1:0], envelope, cfg);
                envelope = nxt.env;
                awaited_outputs.push_back(nxt.res);
            end
        end
        results_pending <= awaited_outputs.size();
        mismatch_count  <= mismatches;
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import bud_pkg::*;

    typedef enum int {
        MIX_ANY,
        MIX_QUIET,
        MIX_MID,
        MIX_LOUD,
        MIX_EDGE
    } level_mix_t;

    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 8;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatch_count;
    int results_pending;
    bit steady_flow = 1'b0;
    int stall_left  = 0;

    logic [15:0] unity_items [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
                                     16'h4000};
    logic [15:0] boost_cut_items [8] = '{16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                         16'h0000, 16'h0100, 16'hF000, 16'h1234};
    logic [15:0] zero_thr_items [5] = '{16'h7FFF, 16'h8000, 16'h0010, 16'h0000, 16'h0000};

    band_up_down_compressor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    band_compressor_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 512));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [14:0] pick_thr();
        case ($urandom_range(0, 4))
            0: return 15'h0000;
            1: return 15'h7FFF;
            2: return 15'($urandom_range(0, 2000));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_depth();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return DEPTH_ONE;
            2: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] make_sample(input level_mix_t mix);
        int          mag;
        logic [15:0] v;
        case (mix)
            MIX_ANY:   return 16'($urandom());
            MIX_QUIET: mag = $urandom_range(0, 400);
            MIX_MID:   mag = $urandom_range(0, 12000);
            MIX_LOUD:  mag = $urandom_range(16000, 32768);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
        v = 16'(mag);
        if ($urandom_range(0, 1) != 0) v = -v;
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits of each write carry junk the block must ignore
    task automatic configure(input logic [15:0] atk, input logic [15:0] rel,
                             input logic [14:0] upt, input logic [14:0] dnt,
                             input logic [15:0] dep);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_ATTACK,  {junk[31:16], atk});
        write_reg(REG_RELEASE, {junk[15:0], rel});
        write_reg(REG_UP,      {junk[31:15], upt});
        write_reg(REG_DOWN,    {junk[16:0], dnt});
        write_reg(REG_DEPTH,   {junk[23:8], dep});
        for (int i = int'(REG_DEPTH) + 1; i < (1 << (ADDR_W - 2)); i++)
            write_reg(3'(i), $urandom());
    endtask

    task automatic send_sample(input logic [15:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    // let the checker's registered count take in the last transfer before polling it
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    initial begin
        int          sent;
        int          burst_len;
        level_mix_t  mix;
        logic [15:0] atk, rel, dep;
        logic [14:0] upt, dnt;

        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero depth, unity gain
        foreach (unity_items[i]) send_sample(unity_items[i]);
        wait_results_done();

        // instant envelope, full depth: capped boost then deep cut
        configure(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'd13107, DEPTH_ONE);
        foreach (boost_cut_items[i]) send_sample(boost_cut_items[i]);
        wait_results_done();

        // zero thresholds, depth beyond one: full cut down to the gain floor
        configure(16'hFFFF, 16'hFFFF, 15'h0000, 15'h0000, 16'hFFFF);
        foreach (zero_thr_items[i]) send_sample(zero_thr_items[i]);
        wait_results_done();

        for (int p = 0; p < PHASES; p++) begin
            atk = pick_coef();
            rel = pick_coef();
            upt = pick_thr();
            dnt = pick_thr();
            dep = pick_depth();
            if (p == 0) atk = 16'h0000;
            configure(atk, rel, upt, dnt, dep);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                mix = level_mix_t'($urandom_range(0, int'(MIX_EDGE)));
                burst_len = $urandom_range(1, 40);
                steady_flow = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
                    send_sample(make_sample(mix));
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) wait_results_done();
            end
            steady_flow = 1'b0;
            wait_results_done();
        end

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
